>>> sv/pwmr_pkg.sv
`default_nettype none
package pwmr_pkg;

   // channel count and field widths
   localparam int CHANNELS    = 2;
   localparam int CH_W        = 1;
   localparam int DUTY_W      = 16;
   localparam int FACTOR_W    = 16;
   localparam int FRAC_BITS   = 12;

   // button debounce window
   localparam int CNT_W                    = 3;
   localparam logic [CNT_W-1:0] WINDOW_TICKS    = CNT_W'(6);
   localparam logic [CNT_W-1:0] PRESS_THRESHOLD = CNT_W'(3);

   // item codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_SETUP = 1'b1;

   // derived widths of the sweep datapath
   localparam int PROD_W = DUTY_W + FACTOR_W;
   localparam int UP_W   = PROD_W - FRAC_BITS;
   localparam int DVD_W  = DUTY_W + FRAC_BITS;
   localparam int STEP_W = $clog2(DVD_W + 1);

   typedef logic [DUTY_W-1:0]          duty_type;
   typedef logic signed [FACTOR_W-1:0] factor_type;

   // direction flip; the most negative factor saturates to the most positive
   function automatic factor_type negate_factor(input factor_type f);
      factor_type r;
      if (f == {1'b1, {(FACTOR_W-1){1'b0}}}) begin
         r = {1'b0, {(FACTOR_W-1){1'b1}}};
      end else begin
         r = -f;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/pwm_exponential_ramp_with_buttons_top.sv
`default_nettype none
// Two-channel exponential PWM duty sweeper with two debounced active-low
// buttons acting on channel 0. A set-up item loads one channel's limits and
// signed Q4.12 factor and answers from ST_DONE. A tick item debounces the
// buttons, then sweeps each channel in turn through one shared datapath: a
// rising channel takes one registered 16x16 multiply, a falling channel runs
// a 28-step restoring divider one quotient bit per cycle, a stopped channel
// is skipped in ST_SELECT. One item is in work at a time; a finished result
// waits in the output register while the next item is taken.
module pwm_exponential_ramp_with_buttons_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_opcode,
   input  wire  [pwmr_pkg::CH_W-1:0]    req_channel,
   input  wire  [pwmr_pkg::DUTY_W-1:0]  req_start_limit,
   input  wire  [pwmr_pkg::DUTY_W-1:0]  req_end_limit,
   input  wire  signed [pwmr_pkg::FACTOR_W-1:0] req_ramp_factor,
   input  wire                          req_down_button_low,
   input  wire                          req_up_button_low,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [pwmr_pkg::DUTY_W-1:0]  rsp_duty_first,
   output logic [pwmr_pkg::DUTY_W-1:0]  rsp_duty_second,
   output logic                         rsp_first_sweeping,
   output logic                         rsp_second_sweeping
);
   import pwmr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELECT,
      ST_MUL,
      ST_DIV,
      ST_DIV_END,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   duty_type   duty_ff   [CHANNELS];
   duty_type   duty_in   [CHANNELS];
   factor_type factor_ff [CHANNELS];
   factor_type factor_in [CHANNELS];
   duty_type   lower_ff  [CHANNELS];
   duty_type   lower_in  [CHANNELS];
   duty_type   upper_ff  [CHANNELS];
   duty_type   upper_in  [CHANNELS];

   logic [CNT_W-1:0] window_ff, window_in;
   logic [CNT_W-1:0] up_cnt_ff, up_cnt_in;
   logic [CNT_W-1:0] dn_cnt_ff, dn_cnt_in;
   logic             up_held_ff, up_held_in;
   logic             dn_held_ff, dn_held_in;

   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DUTY_W-1:0] rem_ff, rem_in;
   logic [DUTY_W-1:0] mag_ff, mag_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              rsp_valid_ff, rsp_valid_in;
   duty_type          rsp_first_ff, rsp_first_in;
   duty_type          rsp_second_ff, rsp_second_in;
   logic              rsp_fsw_ff, rsp_fsw_in;
   logic              rsp_ssw_ff, rsp_ssw_in;

   logic              req_xfer;
   logic              out_free;

   // debounce counts after this tick's samples
   logic [CNT_W-1:0] win_next;
   logic [CNT_W-1:0] up_next;
   logic [CNT_W-1:0] dn_next;
   logic             win_close;
   logic             dn_press;
   logic             up_press;
   duty_type         btn_duty;

   // sweep candidates for the current channel
   duty_type          cur_duty;
   factor_type        cur_factor;
   logic [UP_W-1:0]   up_raw;
   logic [UP_W-1:0]   up_val;
   logic              up_clamp;
   duty_type          dn_sat;
   duty_type          dn_val;
   logic              dn_clamp;
   logic [DUTY_W:0]   div_shift;
   logic              div_bit;
   logic              last_ch;

   assign req_xfer = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign win_next  = window_ff + CNT_W'(1);
   assign up_next   = up_cnt_ff + CNT_W'(!req_up_button_low);
   assign dn_next   = dn_cnt_ff + CNT_W'(!req_down_button_low);
   assign win_close = (win_next >= WINDOW_TICKS);
   assign dn_press  = win_close && (dn_next > PRESS_THRESHOLD);
   assign up_press  = win_close && (up_next > PRESS_THRESHOLD);

   // button effect on channel 0: halve first, then double
   always_comb begin
      btn_duty = duty_ff[0];
      if (dn_press && !dn_held_ff) begin
         btn_duty = btn_duty >> 1;
      end
      if (up_press && !up_held_ff && !btn_duty[DUTY_W-1]) begin
         btn_duty = (btn_duty == '0) ? DUTY_W'(1) : (btn_duty << 1);
      end
   end

   assign cur_duty   = duty_ff[ch_ff];
   assign cur_factor = factor_ff[ch_ff];
   assign last_ch    = (ch_ff == CH_W'(CHANNELS - 1));

   // rising step: truncated product, at least one up, clamp at upper limit
   assign up_raw   = prod_ff[PROD_W-1:FRAC_BITS];
   assign up_val   = (up_raw == UP_W'(cur_duty)) ? up_raw + UP_W'(1) : up_raw;
   assign up_clamp = (up_val >= UP_W'(upper_ff[ch_ff]));

   // falling step: saturated quotient, at least one down, clamp at lower limit
   assign dn_sat   = (|dvd_ff[DVD_W-1:DUTY_W]) ? {DUTY_W{1'b1}} : dvd_ff[DUTY_W-1:0];
   assign dn_val   = ((dn_sat == cur_duty) && (dn_sat != '0)) ? dn_sat - DUTY_W'(1) : dn_sat;
   assign dn_clamp = (dn_val <= lower_ff[ch_ff]);

   // one restoring divide step
   assign div_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign div_bit   = (div_shift >= {1'b0, mag_ff});

   // sequencer and datapath next values
   always_comb begin
      state_in   = state_ff;
      duty_in    = duty_ff;
      factor_in  = factor_ff;
      lower_in   = lower_ff;
      upper_in   = upper_ff;
      window_in  = window_ff;
      up_cnt_in  = up_cnt_ff;
      dn_cnt_in  = dn_cnt_ff;
      up_held_in = up_held_ff;
      dn_held_in = dn_held_ff;
      ch_in      = ch_ff;
      prod_in    = prod_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      mag_in     = mag_ff;
      step_in    = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_fsw_in    = rsp_fsw_ff;
      rsp_ssw_in    = rsp_ssw_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_opcode == OP_SETUP) begin
                  if (int'(req_channel) < CHANNELS) begin
                     duty_in[req_channel]   = req_start_limit;
                     lower_in[req_channel]  = req_start_limit;
                     upper_in[req_channel]  = req_end_limit;
                     factor_in[req_channel] = req_ramp_factor;
                  end
                  state_in = ST_DONE;
               end else begin
                  window_in = win_next;
                  up_cnt_in = up_next;
                  dn_cnt_in = dn_next;
                  if (win_close) begin
                     duty_in[0] = btn_duty;
                     if (dn_press) begin
                        dn_held_in   = 1'b1;
                        factor_in[0] = '0;
                     end else begin
                        dn_held_in = 1'b0;
                     end
                     if (up_press) begin
                        if (!up_held_ff) begin
                           up_held_in   = 1'b1;
                           factor_in[0] = '0;
                        end
                     end else begin
                        up_held_in = 1'b0;
                     end
                     window_in = '0;
                     up_cnt_in = '0;
                     dn_cnt_in = '0;
                  end
                  ch_in    = '0;
                  state_in = ST_SELECT;
               end
            end
         end

         ST_SELECT: begin
            if (cur_factor == '0) begin
               if (last_ch) begin
                  state_in = ST_DONE;
               end else begin
                  ch_in = ch_ff + CH_W'(1);
               end
            end else if (!cur_factor[FACTOR_W-1]) begin
               prod_in  = PROD_W'(cur_duty) * PROD_W'(unsigned'(cur_factor));
               state_in = ST_MUL;
            end else begin
               dvd_in   = {cur_duty, {FRAC_BITS{1'b0}}};
               rem_in   = '0;
               mag_in   = unsigned'(-cur_factor);
               step_in  = '0;
               state_in = ST_DIV;
            end
         end

         ST_MUL: begin
            if (up_clamp) begin
               duty_in[ch_ff]   = upper_ff[ch_ff];
               factor_in[ch_ff] = negate_factor(cur_factor);
            end else begin
               duty_in[ch_ff] = up_val[DUTY_W-1:0];
            end
            if (last_ch) begin
               state_in = ST_DONE;
            end else begin
               ch_in    = ch_ff + CH_W'(1);
               state_in = ST_SELECT;
            end
         end

         ST_DIV: begin
            rem_in  = div_bit ? DUTY_W'(div_shift - {1'b0, mag_ff})
                              : div_shift[DUTY_W-1:0];
            dvd_in  = {dvd_ff[DVD_W-2:0], div_bit};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DVD_W - 1)) begin
               state_in = ST_DIV_END;
            end
         end

         ST_DIV_END: begin
            if (dn_clamp) begin
               duty_in[ch_ff]   = lower_ff[ch_ff];
               factor_in[ch_ff] = negate_factor(cur_factor);
            end else begin
               duty_in[ch_ff] = dn_val;
            end
            if (last_ch) begin
               state_in = ST_DONE;
            end else begin
               ch_in    = ch_ff + CH_W'(1);
               state_in = ST_SELECT;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = duty_ff[0];
               rsp_fsw_in    = (factor_ff[0] != '0);
               rsp_second_in = (CHANNELS > 1) ? duty_ff[CHANNELS-1] : '0;
               rsp_ssw_in    = (CHANNELS > 1) ? (factor_ff[CHANNELS-1] != '0) : 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, channel stores and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         duty_ff      <= '{default: '0};
         factor_ff    <= '{default: '0};
         lower_ff     <= '{default: '0};
         upper_ff     <= '{default: '0};
         window_ff    <= '0;
         up_cnt_ff    <= '0;
         dn_cnt_ff    <= '0;
         up_held_ff   <= 1'b0;
         dn_held_ff   <= 1'b0;
         ch_ff        <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         duty_ff      <= duty_in;
         factor_ff    <= factor_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         window_ff    <= window_in;
         up_cnt_ff    <= up_cnt_in;
         dn_cnt_ff    <= dn_cnt_in;
         up_held_ff   <= up_held_in;
         dn_held_ff   <= dn_held_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff       <= prod_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      mag_ff        <= mag_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_fsw_ff    <= rsp_fsw_in;
      rsp_ssw_ff    <= rsp_ssw_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_duty_first      = rsp_first_ff;
   assign rsp_duty_second     = rsp_second_ff;
   assign rsp_first_sweeping  = rsp_fsw_ff;
   assign rsp_second_sweeping = rsp_ssw_ff;

endmodule
`default_nettype wire
